// File: design/ftoi_pkg.sv
// Shared types, constants and codes for the scaled float-to-int converter.
package ftoi_pkg;

  typedef enum logic [1:0] {
    RM_TRUNC   = 2'd0,
    RM_NEAREST = 2'd1,
    RM_FLOOR   = 2'd2,
    RM_CEIL    = 2'd3
  } round_mode_e;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_MODE  = 2'd1
  } reg_index_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MantW   = 24;
  localparam int unsigned ExpW    = 10;

  typedef struct packed {
    logic [31:0] float_bits;
    logic        end_of_vector;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] int_result;
    logic               overflow_flag;
    logic               invalid_flag;
    logic               end_of_vector_out;
  } out_word_t;

  // Decoded operand after the first stage.
  typedef struct packed {
    logic                   neg;
    logic                   is_nan;
    logic                   is_inf;
    logic                   is_zero;
    logic [MantW-1:0]       mant;
    logic signed [ExpW-1:0] shift;
    round_mode_e            mode;
    logic                   eov;
  } dec_t;

  // Aligned magnitude and fraction class after the second stage.
  typedef struct packed {
    logic        neg;
    logic        is_nan;
    logic        is_inf;
    logic        big;
    logic [31:0] mag;
    logic [1:0]  cls;
    round_mode_e mode;
    logic        eov;
  } aln_t;

  localparam logic [1:0] ClsExact = 2'd0;
  localparam logic [1:0] ClsBelow = 2'd1;
  localparam logic [1:0] ClsHalf  = 2'd2;
  localparam logic [1:0] ClsAbove = 2'd3;

endpackage

// File: design/ftoi_decode.sv
// First stage: decode the float fields and fold in the scale exponent.
module ftoi_decode import ftoi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  in_word_t          word_i,
  input  logic signed [7:0] scale_i,
  input  round_mode_e       mode_i,
  output logic              valid_o,
  output dec_t              dec_o
);

  logic [7:0]  ex;
  logic [22:0] fr;
  dec_t        dec_d, dec_q;
  logic        valid_q;
  logic signed [ExpW-1:0] e_unb;

  assign ex = word_i.float_bits[30:23];
  assign fr = word_i.float_bits[22:0];

  always_comb begin
    e_unb = (ex == 8'd0) ? -ExpW'(signed'(10'sd149))
                         : signed'({2'b00, ex}) - ExpW'(signed'(10'sd150));
    dec_d.neg     = word_i.float_bits[31];
    dec_d.is_nan  = (ex == 8'hFF) && (fr != 23'd0);
    dec_d.is_inf  = (ex == 8'hFF) && (fr == 23'd0);
    dec_d.is_zero = (ex == 8'd0) && (fr == 23'd0);
    dec_d.mant    = {(ex != 8'd0), fr};
    dec_d.shift   = e_unb + ExpW'(scale_i);
    dec_d.mode    = mode_i;
    dec_d.eov     = word_i.end_of_vector;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

// File: design/ftoi_align.sv
// Second stage: shift the significand into place and classify the fraction.
module ftoi_align import ftoi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  dec_t dec_i,
  output logic valid_o,
  output aln_t aln_o
);

  aln_t        aln_d, aln_q;
  logic        valid_q;
  logic [63:0] wide;
  logic [5:0]  rsh;
  logic [4:0]  lsh;
  logic [39:0] frac;

  always_comb begin
    aln_d.neg    = dec_i.neg;
    aln_d.is_nan = dec_i.is_nan;
    aln_d.is_inf = dec_i.is_inf;
    aln_d.mode   = dec_i.mode;
    aln_d.eov    = dec_i.eov;
    aln_d.big    = 1'b0;
    aln_d.mag    = 32'd0;
    aln_d.cls    = ClsExact;
    rsh  = 6'd0;
    lsh  = 5'd0;
    wide = 64'd0;
    frac = 40'd0;
    if (dec_i.is_zero || dec_i.is_nan || dec_i.is_inf) begin
      aln_d.cls = ClsExact;
    end else if (!dec_i.shift[ExpW-1]) begin
      if (dec_i.shift > ExpW'(31)) begin
        aln_d.big = 1'b1;
      end else begin
        lsh = dec_i.shift[4:0];
        wide = {40'd0, dec_i.mant} << lsh;
        aln_d.mag = wide[31:0];
        aln_d.big = (wide[63:32] != 32'd0);
      end
    end else if (dec_i.shift < -ExpW'(40)) begin
      aln_d.cls = ClsBelow;
    end else begin
      rsh = 6'(-dec_i.shift);
      // mant sits at bits [63:40]; the right shift leaves integer in [63:40]
      wide = {dec_i.mant, 40'd0} >> rsh;
      aln_d.mag = {8'd0, wide[63:40]};
      frac = wide[39:0];
      if (frac == 40'd0) begin
        aln_d.cls = ClsExact;
      end else if (!frac[39]) begin
        aln_d.cls = ClsBelow;
      end else if (frac[38:0] == 39'd0) begin
        aln_d.cls = ClsHalf;
      end else begin
        aln_d.cls = ClsAbove;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      aln_q <= aln_d;
    end
  end

  assign valid_o = valid_q;
  assign aln_o   = aln_q;

endmodule

// File: design/ftoi_round.sv
// Third stage: round, negate and saturate into the output register.
module ftoi_round import ftoi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      valid_i,
  input  aln_t      aln_i,
  output logic      valid_o,
  output out_word_t word_o
);

  out_word_t   word_d, word_q;
  logic        valid_q;
  logic        inc;
  logic [32:0] mag;

  always_comb begin
    case (aln_i.mode)
      RM_NEAREST: inc = aln_i.neg ? (aln_i.cls == ClsAbove)
                                  : (aln_i.cls == ClsHalf || aln_i.cls == ClsAbove);
      RM_FLOOR:   inc = aln_i.neg && (aln_i.cls != ClsExact);
      RM_CEIL:    inc = !aln_i.neg && (aln_i.cls != ClsExact);
      default:    inc = 1'b0;
    endcase
    mag = {1'b0, aln_i.mag} + {32'd0, inc};
    word_d.end_of_vector_out = aln_i.eov;
    word_d.invalid_flag      = aln_i.is_nan;
    word_d.overflow_flag     = 1'b0;
    word_d.int_result        = 32'sd0;
    if (aln_i.is_nan) begin
      word_d.int_result = 32'sd0;
    end else if (aln_i.neg) begin
      if (aln_i.is_inf || aln_i.big || mag > 33'h0_8000_0000) begin
        word_d.overflow_flag = 1'b1;
        word_d.int_result    = 32'sh8000_0000;
      end else begin
        word_d.int_result = signed'(32'd0 - mag[31:0]);
      end
    end else begin
      if (aln_i.is_inf || aln_i.big || mag > 33'h0_7FFF_FFFF) begin
        word_d.overflow_flag = 1'b1;
        word_d.int_result    = 32'sh7FFF_FFFF;
      end else begin
        word_d.int_result = signed'(mag[31:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// File: design/float_to_int_scaled_rounding.sv
// Top level of the scaled float-to-int32 converter.
//
// Input channel in_valid_i / in_stall_o carries one float word per cycle;
// output channel out_valid_o / out_stall_i returns one integer word each.
// A word is taken on an edge where valid is high and stall is low.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the signed scale exponent, index 1 the rounding mode, others
// are dropped. cfg_ready_o is always high; write only while idle.
// Three register stages: decode, align, round. An accepted word passes
// through each in turn, then out_valid_o rises and the word can leave.
// Throughput is one word per cycle while in_stall_o stays low.
// A stage that holds a word advances only when the output is free or a
// bubble ahead can absorb it; when out_stall_i is high the pipeline holds
// and in_stall_o rises once every stage is full.
// Reset clears all valid bits, sets scale to 0 and mode to truncate.
module float_to_int_scaled_rounding import ftoi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_word_t          out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic signed [7:0] scale_q;
  round_mode_e       mode_q;
  logic              v1, v2, v3;
  logic              adv1, adv2, adv3;
  dec_t              dec;
  aln_t              aln;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 8'sd0;
      mode_q  <= RM_TRUNC;
    end else if (cfg_valid_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_SCALE: scale_q <= signed'(cfg_data_i);
        REG_MODE:  mode_q  <= round_mode_e'(cfg_data_i[1:0]);
        default:   ;
      endcase
    end
  end

  assign adv3 = !v3 || !out_stall_i;
  assign adv2 = adv3 || !v2;
  assign adv1 = adv2 || !v1;
  assign in_stall_o = !adv1;

  ftoi_decode u_dec (
    .clk_i, .rst_ni, .adv_i(adv1), .valid_i(in_valid_i), .word_i(in_word_i),
    .scale_i(scale_q), .mode_i(mode_q), .valid_o(v1), .dec_o(dec)
  );

  ftoi_align u_aln (
    .clk_i, .rst_ni, .adv_i(adv2), .valid_i(v1), .dec_i(dec),
    .valid_o(v2), .aln_o(aln)
  );

  ftoi_round u_rnd (
    .clk_i, .rst_ni, .adv_i(adv3), .valid_i(v2), .aln_i(aln),
    .valid_o(v3), .word_o(out_word_o)
  );

  assign out_valid_o = v3;

endmodule

// File: design/ftoi_checker.sv
// Port-level checks for the converter, bound to the top level.
module ftoi_checker import ftoi_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  a_nan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.invalid_flag |->
      out_word_o.int_result == 32'sd0 && !out_word_o.overflow_flag)
    else $error("invalid word not zero");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("accepted word missing after three cycles");

endmodule

bind float_to_int_scaled_rounding ftoi_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_word_o
);
